// File: rtl/psb_pkg.sv
package psb_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_ROTATE = 3'd2,
    OP_DELETE = 3'd3,
    OP_DUMP   = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_FIN,
    S_DREAD,
    S_DLOAD
  } state_e;

  // how the new image is built from the current bank during a copy
  typedef enum logic [1:0] {
    MD_INS,
    MD_DEL,
    MD_ROT
  } mode_e;

endpackage

// File: rtl/psb_in_if.sv
interface psb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic signed [7:0]  position;
  logic signed [7:0]  steps;

  modport source (output valid, opcode, value, position, steps, input ready);
  modport sink   (input valid, opcode, value, position, steps, output ready);
endinterface

// File: rtl/psb_out_if.sv
interface psb_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic [5:0]         element_index;
  logic [6:0]         length;
  logic               last;

  modport source (output valid, status, element, element_index, length, last, input ready);
  modport sink   (input valid, status, element, element_index, length, last, output ready);
endinterface

// File: rtl/positional_sequence_buffer.sv
// Ordered sequence of up to CAPACITY signed 32-bit values, held in two
// synchronous RAM banks (registered read) plus an element count. One
// bank is live; insert, delete and rotate rebuild the sequence into the other
// bank, one element per cycle through the read port, then swap banks. One
// operation is in flight at a time. Append, rejected operations and a rotate
// that moves nothing go from accept through S_FIN to the output register;
// insert/delete/rotate copy each element, retire the last write, swap banks
// and then load the output register, and a dump reads and then loads each
// element in turn, each element a separate beat with last on the final one.
// Output beats sit in an output register, so a pending beat does not stop
// the next operation being accepted once the current one has finished. No
// clearing pass is needed after reset.
module positional_sequence_buffer #(
  parameter int CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  psb_in_if.sink     in_i,
  psb_out_if.source  out_o
);
  import psb_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // two RAM banks
  logic signed [31:0] mem0 [CAPACITY];
  logic signed [31:0] mem1 [CAPACITY];
  logic signed [31:0] rd0_q, rd1_q, rd_cur;
  logic               we0, we1, re0, re1;
  logic [IW-1:0]      wa0, wa1;
  logic signed [31:0] wd0, wd1;

  logic               we_cur, we_oth, re;
  logic [IW-1:0]      wa_cur, wa_oth, rd_addr;
  logic signed [31:0] wd_cur, wd_oth;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic               bank_q, bank_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      j_q, j_d;
  logic [CW-1:0]      p_q, p_d;
  logic [CW-1:0]      r_q, r_d;
  logic [CW-1:0]      newn_q, newn_d;
  logic signed [31:0] val_q, val_d;
  status_e            status_q, status_d;
  logic               wr_vld_q, wr_vld_d;
  logic [IW-1:0]      wr_idx_q, wr_idx_d;
  logic               wr_val_q, wr_val_d;

  logic               out_vld_q, out_vld_d;
  status_e            o_status_q, o_status_d;
  logic signed [31:0] o_elem_q, o_elem_d;
  logic [5:0]         o_idx_q, o_idx_d;
  logic [6:0]         o_len_q, o_len_d;
  logic               o_last_q, o_last_d;

  logic               in_fire, out_free, is_ins_slot;
  logic [7:0]         n8, pos8, steps8;
  logic [CW:0]        j_x, n_x, k_x, src_x;

  always_ff @(posedge clk_i) begin
    if (we0) mem0[wa0] <= wd0;
    if (re0) rd0_q <= mem0[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we1) mem1[wa1] <= wd1;
    if (re1) rd1_q <= mem1[rd_addr];
  end

  // bank_q selects the live bank; the other one receives copies
  assign we0 = bank_q ? we_oth : we_cur;
  assign we1 = bank_q ? we_cur : we_oth;
  assign wa0 = bank_q ? wa_oth : wa_cur;
  assign wa1 = bank_q ? wa_cur : wa_oth;
  assign wd0 = bank_q ? wd_oth : wd_cur;
  assign wd1 = bank_q ? wd_cur : wd_oth;
  assign re0 = re & ~bank_q;
  assign re1 = re & bank_q;
  assign rd_cur = bank_q ? rd1_q : rd0_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign n8     = 8'(count_q);
  assign pos8   = in_i.position;
  assign steps8 = in_i.steps;

  // source index of the new element j within the live bank
  assign j_x = {1'b0, j_q};
  assign n_x = {1'b0, count_q};
  assign k_x = j_x + {1'b0, r_q};
  always_comb begin
    unique case (mode_q)
      MD_INS:  src_x = (j_q < p_q) ? j_x : j_x - 1'b1;
      MD_DEL:  src_x = (j_q < p_q) ? j_x : j_x + 1'b1;
      MD_ROT:  src_x = (k_x >= n_x) ? k_x - n_x : k_x;
      default: src_x = j_x;
    endcase
  end
  assign is_ins_slot = (mode_q == MD_INS) && (j_q == p_q);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    bank_d     = bank_q;
    count_d    = count_q;
    j_d        = j_q;
    p_d        = p_q;
    r_d        = r_q;
    newn_d     = newn_q;
    val_d      = val_q;
    status_d   = status_q;
    wr_vld_d   = 1'b0;
    wr_idx_d   = wr_idx_q;
    wr_val_d   = wr_val_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    o_status_d = o_status_q;
    o_elem_d   = o_elem_q;
    o_idx_d    = o_idx_q;
    o_len_d    = o_len_q;
    o_last_d   = o_last_q;
    we_cur     = 1'b0;
    wa_cur     = count_q[IW-1:0];
    wd_cur     = in_i.value;
    we_oth     = wr_vld_q;
    wa_oth     = wr_idx_q;
    wd_oth     = wr_val_q ? val_q : rd_cur;
    re         = 1'b0;
    rd_addr    = j_q[IW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d    = in_i.value;
          status_d = ST_OK;
          j_d      = '0;
          state_d  = S_FIN;
          case (opcode_e'(in_i.opcode))
            OP_APPEND: begin
              if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                we_cur  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            OP_INSERT: begin
              if (pos8[7] || pos8 > n8) begin
                status_d = ST_RANGE;
              end else if (count_q >= CW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                mode_d  = MD_INS;
                p_d     = CW'(pos8);
                newn_d  = count_q + 1'b1;
                state_d = S_COPY;
              end
            end
            OP_ROTATE: begin
              if (count_q >= CW'(2)) begin
                mode_d = MD_ROT;
                newn_d = count_q;
                if (steps8[7] || steps8 == 8'd0) begin
                  r_d     = CW'(1);
                  state_d = S_COPY;
                end else if (steps8 < n8) begin
                  r_d     = CW'(steps8);
                  state_d = S_COPY;
                end
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos8[7] || pos8 >= n8) begin
                status_d = ST_RANGE;
              end else begin
                mode_d  = MD_DEL;
                p_d     = CW'(pos8);
                newn_d  = count_q - 1'b1;
                state_d = S_COPY;
              end
            end
            OP_DUMP: begin
              if (count_q != '0) state_d = S_DREAD;
            end
            default: ;
          endcase
        end
      end

      S_COPY: begin
        // read the source of new element j from the live bank, write it to the other bank next cycle
        if (j_q != newn_q) begin
          wr_vld_d = 1'b1;
          wr_idx_d = j_q[IW-1:0];
          wr_val_d = is_ins_slot;
          re       = !is_ins_slot;
          rd_addr  = src_x[IW-1:0];
          j_d      = j_q + 1'b1;
        end else if (!wr_vld_q) begin
          bank_d  = !bank_q;
          count_d = newn_q;
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          o_status_d = status_q;
          o_elem_d   = '0;
          o_idx_d    = '0;
          o_len_d    = 7'(count_q);
          o_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_DREAD: begin
        re      = 1'b1;
        state_d = S_DLOAD;
      end

      S_DLOAD: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          o_status_d = ST_OK;
          o_elem_d   = rd_cur;
          o_idx_d    = 6'(j_q[IW-1:0]);
          o_len_d    = 7'(count_q);
          o_last_d   = (j_x + 1'b1 == n_x);
          j_d        = j_q + 1'b1;
          state_d    = (j_x + 1'b1 == n_x) ? S_IDLE : S_DREAD;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bank_q    <= 1'b0;
      count_q   <= '0;
      wr_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      bank_q    <= bank_d;
      count_q   <= count_d;
      wr_vld_q  <= wr_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    j_q        <= j_d;
    p_q        <= p_d;
    r_q        <= r_d;
    newn_q     <= newn_d;
    val_q      <= val_d;
    status_q   <= status_d;
    wr_idx_q   <= wr_idx_d;
    wr_val_q   <= wr_val_d;
    o_status_q <= o_status_d;
    o_elem_q   <= o_elem_d;
    o_idx_q    <= o_idx_d;
    o_len_q    <= o_len_d;
    o_last_q   <= o_last_d;
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = o_status_q;
  assign out_o.element       = o_elem_q;
  assign out_o.element_index = o_idx_q;
  assign out_o.length        = o_len_q;
  assign out_o.last          = o_last_q;

endmodule

// File: test/positional_sequence_buffer_test.sv
`timescale 1ns / 1ps

module positional_sequence_buffer_test;
  import psb_pkg::*;

  localparam int CAPACITY = 16;
  localparam int N_ROWS = 25;
  localparam int N_RANDOM = 144;
  localparam int N_CALM = 40;
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [6:0]         length;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic signed [7:0]  pos;
    logic signed [7:0]  stp;
    int                 reps;
    bit                 typed;
    status_e            st;
    int                 len;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  psb_in_if  in_if ();
  psb_out_if out_if ();

  positional_sequence_buffer #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predicted contents of the sequence
  logic signed [31:0] seq_mem [CAPACITY];
  int                 seq_len;
  beat_t              op_beats[$];
  beat_t              pending_beats[$];
  int                 err_cnt;
  bit                 calm;
  script_row_t        script [N_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic beat_t make_beat(status_e st, logic signed [31:0] elem, int idx,
                                      int len, logic lst);
    beat_t b;
    b.status        = st;
    b.element       = elem;
    b.element_index = 6'(idx);
    b.length        = 7'(len);
    b.last          = lst;
    return b;
  endfunction

  // Applies one operation to the predicted sequence; beats land in op_beats.
  function automatic void apply_to_sequence(logic [2:0] op, logic signed [31:0] val,
                                            logic signed [7:0] pos, logic signed [7:0] stp);
    int                 p;
    int                 s;
    int                 r;
    status_e            st;
    logic signed [31:0] rot_buf [CAPACITY];
    p = pos;
    s = stp;
    st = ST_OK;
    op_beats.delete();
    case (op)
      OP_APPEND: begin
        if (seq_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          seq_mem[seq_len] = val;
          seq_len++;
        end
      end
      OP_INSERT: begin
        // range check wins over full
        if (p < 0 || p > seq_len) begin
          st = ST_RANGE;
        end else if (seq_len >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          for (int i = seq_len; i > p; i--) seq_mem[i] = seq_mem[i - 1];
          seq_mem[p] = val;
          seq_len++;
        end
      end
      OP_ROTATE: begin
        if (seq_len >= 2) begin
          r = (s < 1) ? 1 : (s < seq_len) ? s : 0;
          if (r != 0) begin
            for (int i = 0; i < seq_len; i++) rot_buf[i] = seq_mem[(i + r) % seq_len];
            for (int i = 0; i < seq_len; i++) seq_mem[i] = rot_buf[i];
          end
        end
      end
      OP_DELETE: begin
        if (seq_len == 0) begin
          st = ST_EMPTY;
        end else if (p < 0 || p >= seq_len) begin
          st = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < seq_len; i++) seq_mem[i] = seq_mem[i + 1];
          seq_len--;
        end
      end
      OP_DUMP: begin
        if (seq_len == 0) begin
          op_beats.push_back(make_beat(ST_OK, 0, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < seq_len; i++)
            op_beats.push_back(make_beat(ST_OK, seq_mem[i], i, seq_len, i + 1 == seq_len));
        end
        return;
      end
      default: ;
    endcase
    op_beats.push_back(make_beat(st, 0, 0, seq_len, 1'b1));
  endfunction

  task automatic send_item(logic [2:0] op, logic signed [31:0] val,
                           logic signed [7:0] pos, logic signed [7:0] stp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.value    <= val;
    in_if.position <= pos;
    in_if.steps    <= stp;
    do @(posedge clk_i); while (!in_if.ready);
    apply_to_sequence(op, val, pos, stp);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      err_cnt++;
    end
  endfunction

  // output side: random stalls, with quiet stretches
  initial begin
    int  hold;
    bit  gappy;
    hold = 0;
    gappy = 1'b1;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 39) == 0) gappy = !gappy;
      if (hold != 0 && !calm) begin
        out_if.ready <= 1'b0;
        hold--;
      end else if (!calm && gappy && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        hold = $urandom_range(1, 15) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t want;
    if (rst_ni === 1'b1 && out_if.valid && out_if.ready) begin
      if (pending_beats.size() == 0) begin
        $error("beat with nothing pending: status %0d length %0d", out_if.status,
               out_if.length);
        err_cnt++;
      end else begin
        want = pending_beats.pop_front();
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("element", want.element, out_if.element);
        check_field("element_index", 32'(want.element_index), 32'(out_if.element_index));
        check_field("length", 32'(want.length), 32'(out_if.length));
        check_field("last", 32'(want.last), 32'(out_if.last));
      end
    end
  end

  initial begin
    int                 k;
    int                 j;
    int                 goal;
    int                 roll;
    logic [2:0]         op;
    logic signed [31:0] val;
    logic signed [7:0]  pos;
    logic signed [7:0]  stp;

    err_cnt = 0;
    calm = 1'b0;
    seq_len = 0;
    goal = 0;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.opcode   <= OP_APPEND;
    in_if.value    <= '0;
    in_if.position <= '0;
    in_if.steps    <= '0;

    //           op           value            pos       steps  reps typed status    len
    script = '{
      '{OP_DUMP,     32'sd0,          8'sd0,    8'sd0,    1, 1'b1, ST_OK,    0},
      '{OP_DELETE,   32'sd0,          -8'sd128, 8'sd0,    1, 1'b1, ST_EMPTY, 0},
      '{OP_ROTATE,   32'sd0,          8'sd0,    8'sd5,    1, 1'b1, ST_OK,    0},
      '{OP_INSERT,   32'sd1,          8'sd1,    8'sd0,    1, 1'b1, ST_RANGE, 0},
      '{OP_INSERT,   32'sd1,          -8'sd1,   8'sd0,    1, 1'b1, ST_RANGE, 0},
      '{OP_INSERT,   32'sh8000_0000,  8'sd0,    8'sd0,    1, 1'b1, ST_OK,    1},
      '{OP_ROTATE,   32'sd0,          8'sd0,    -8'sd1,   1, 1'b1, ST_OK,    1},
      '{OP_APPEND,   32'sh7fff_ffff,  8'sd0,    8'sd0,    1, 1'b1, ST_OK,    2},
      '{OP_INSERT,   -32'sd1,         8'sd2,    8'sd0,    1, 1'b1, ST_OK,    3},
      '{OP_ROTATE,   32'sd0,          8'sd0,    -8'sd128, 1, 1'b0, ST_OK,    0},
      '{OP_ROTATE,   32'sd0,          8'sd0,    8'sd2,    1, 1'b0, ST_OK,    0},
      '{OP_ROTATE,   32'sd0,          8'sd0,    8'sd3,    1, 1'b0, ST_OK,    0},
      '{OP_DELETE,   32'sd0,          8'sd3,    8'sd0,    1, 1'b1, ST_RANGE, 3},
      '{OP_DELETE,   32'sd0,          -8'sd1,   8'sd0,    1, 1'b1, ST_RANGE, 3},
      '{OP_DUMP,     32'sd0,          8'sd0,    8'sd0,    1, 1'b0, ST_OK,    0},
      '{OP_APPEND,   32'sh0f0f_0f00,  8'sd0,    8'sd0,   13, 1'b0, ST_OK,    0},
      '{OP_APPEND,   32'sd9,          8'sd0,    8'sd0,    1, 1'b1, ST_FULL,  16},
      '{OP_INSERT,   32'sd9,          8'sd17,   8'sd0,    1, 1'b1, ST_RANGE, 16},
      '{OP_INSERT,   32'sd9,          8'sd16,   8'sd0,    1, 1'b1, ST_FULL,  16},
      '{OP_ROTATE,   32'sd0,          8'sd0,    8'sd127,  1, 1'b0, ST_OK,    0},
      '{OP_ROTATE,   32'sd0,          8'sd0,    8'sd15,   1, 1'b0, ST_OK,    0},
      '{OP_DELETE,   32'sd0,          8'sd0,    8'sd0,    1, 1'b1, ST_OK,    15},
      '{OP_DUMP,     32'sd0,          8'sd0,    8'sd0,    1, 1'b0, ST_OK,    0},
      '{OP_UNDEF_LO, 32'sd0,          8'sd0,    8'sd0,    1, 1'b1, ST_OK,    15},
      '{OP_UNDEF_HI, 32'sd0,          8'sd0,    8'sd0,    1, 1'b1, ST_OK,    15}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_ROWS; k++) begin
      for (j = 0; j < script[k].reps; j++) begin
        send_item(script[k].op, script[k].val + j, script[k].pos, script[k].stp);
        if (script[k].typed)
          pending_beats.push_back(make_beat(script[k].st, 0, 0, script[k].len, 1'b1));
        else
          foreach (op_beats[b]) pending_beats.push_back(op_beats[b]);
      end
    end

    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - N_CALM) calm = 1'b1;
      // length target wanders so both full and empty get visited
      if (k % 20 == 0) begin
        case ($urandom_range(0, 3))
          0: goal = 0;
          1: goal = CAPACITY;
          default: goal = $urandom_range(1, CAPACITY - 1);
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) op = OP_DUMP;
      else if (roll < 11) op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      else if (roll < 26) op = OP_ROTATE;
      else if (seq_len < goal) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      else if (seq_len > goal) op = OP_DELETE;
      else begin
        case ($urandom_range(0, 2))
          0: op = OP_APPEND;
          1: op = OP_INSERT;
          default: op = OP_DELETE;
        endcase
      end

      if ($urandom_range(0, 6) == 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7fff_ffff;
          2: val = 32'sd0;
          default: val = -32'sd1;
        endcase
      end else begin
        val = $urandom;
      end

      if ($urandom_range(0, 4) == 0) pos = 8'($urandom);
      else if (op == OP_DELETE) pos = (seq_len == 0) ? 8'sd0 : 8'($urandom_range(0, seq_len - 1));
      else pos = 8'($urandom_range(0, seq_len));

      if ($urandom_range(0, 3) == 0) stp = 8'($urandom);
      else stp = 8'($urandom_range(0, seq_len + 3)) - 8'sd2;

      send_item(op, val, pos, stp);
      foreach (op_beats[b]) pending_beats.push_back(op_beats[b]);
    end
    in_if.valid <= 1'b0;

    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
